@@ rtl/lds_pkg.sv @@
// Shared types and constants for the light direction smoother.
// Holds the transaction structs, sequencer states and shared-unit request types.
// No dependencies.
`default_nettype none

package lds_pkg;

    // Q1.14 constants
    localparam logic signed [15:0] ONE_Q14   = 16'sd16384;
    localparam logic signed [15:0] DEF_X     = 16'sd7373;
    localparam logic signed [15:0] DEF_Y     = -16'sd14746;
    localparam logic signed [15:0] GUARD_Q14 = 16'sd164;
    localparam logic [29:0]        H2_MIN    = 30'd2;
    localparam logic [7:0]         CFG_RESET = 8'd25;

    // Number of quotient bits and root steps of the shared unit
    localparam int DIV_STEPS  = 17;
    localparam int SQRT_STEPS = 32;

    typedef struct packed {
        logic signed [15:0] target_x;
        logic signed [15:0] target_y;
        logic signed [15:0] target_z;
        logic [7:0]         elapsed_ticks;
    } t_target;

    typedef struct packed {
        logic signed [15:0] dir_x;
        logic signed [15:0] dir_y;
        logic signed [15:0] dir_z;
    } t_dir;

    typedef enum logic [0:0] {
        OP_DIV,
        OP_SQRT
    } t_unit_op;

    typedef struct packed {
        logic       start;
        t_unit_op   op;
        logic [63:0] arg;
        logic [32:0] den;
    } t_unit_req;

    typedef struct packed {
        logic        done;
        logic [31:0] res;
    } t_unit_rsp;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_BL_MUL,
        ST_BL_DIV,
        ST_BL_WAIT,
        ST_BL_END,
        ST_GUARD,
        ST_NM_MUL,
        ST_NM_ACC,
        ST_NM_SQRT,
        ST_NM_SQWAIT,
        ST_NM_DIV,
        ST_NM_DIVWAIT,
        ST_H2_MUL,
        ST_H2_ACC,
        ST_Y_MUL,
        ST_Y_CHK,
        ST_Y_SQWAIT,
        ST_EMIT
    } t_state;

    // Where the normalize routine continues
    typedef enum logic [1:0] {
        RET_RAW,
        RET_SHAL,
        RET_OUT
    } t_ret;

endpackage

`default_nettype wire

@@ rtl/lds_unit.sv @@
// Shared iterative unit: restoring division (one quotient bit per cycle)
// or integer square root (one root bit per cycle). Uses lds_pkg.
`default_nettype none

module lds_unit (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire lds_pkg::t_unit_req i_req,
    output lds_pkg::t_unit_rsp      o_rsp
);
    import lds_pkg::*;

    logic        r_busy;
    logic        r_done;
    t_unit_op    r_op;
    logic [5:0]  r_cnt;
    logic [63:0] r_x;
    logic [63:0] r_r;
    logic [63:0] r_b;
    logic [63:0] w_trial;

    assign w_trial = r_r + r_b;

    // Control: busy flag and done pulse, ended by the step count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == 6'd0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // Datapath: load operands on start, then advance one step a cycle while busy
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_op <= i_req.op;
            r_x  <= i_req.arg;
            r_r  <= 64'd0;
            if (i_req.op == OP_DIV) begin
                r_b   <= 64'(i_req.den) << (DIV_STEPS - 1);
                r_cnt <= 6'(DIV_STEPS - 1);
            end else begin
                r_b   <= 64'd1 << 62;
                r_cnt <= 6'(SQRT_STEPS - 1);
            end
        end else if (r_busy) begin
            r_cnt <= r_cnt - 6'd1;
            if (r_op == OP_DIV) begin
                if (r_x >= r_b) begin
                    r_x <= r_x - r_b;
                    r_r <= {r_r[62:0], 1'b1};
                end else begin
                    r_r <= {r_r[62:0], 1'b0};
                end
                r_b <= r_b >> 1;
            end else begin
                if (r_x >= w_trial) begin
                    r_x <= r_x - w_trial;
                    r_r <= (r_r >> 1) + r_b;
                end else begin
                    r_r <= r_r >> 1;
                end
                r_b <= r_b >> 2;
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.res  = r_r[31:0];

endmodule

`default_nettype wire

@@ rtl/light_direction_smoother.sv @@
// Light direction smoother top level: sequencer, state vectors and one multiplier.
// Uses lds_pkg and the shared divide / square-root unit lds_unit.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_data) carries one target
//   direction and elapsed tick count per transaction. Output channel
//   (o_out_valid / i_out_stall / o_out_data) returns one smoothed unit
//   direction per input transaction, in order.
//   i_cfg_we / i_cfg_data write ticks_for_full_blend; write only while idle.
// Computation:
//   Each transaction runs six blend divisions and three, six or nine
//   normalize divisions, plus one to four square roots, all through lds_unit.
//   The input stalls for the whole computation; a new transaction is taken
//   in the cycle after the result is loaded into the output register.
// Reset:
//   Synchronous, active low. Both state vectors clear to zero and the
//   blend register returns to 25.
// Output stall:
//   The result waits in the output register; a finished computation holds
//   until that register is free, so nothing is dropped.
`default_nettype none

module light_direction_smoother (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_stall,
    input  wire lds_pkg::t_target i_in_data,
    output logic                 o_out_valid,
    input  wire logic            i_out_stall,
    output lds_pkg::t_dir        o_out_data,
    input  wire logic            i_cfg_we,
    input  wire logic [7:0]      i_cfg_data
);
    import lds_pkg::*;

    t_state             r_state, n_state;
    t_ret               r_ret, n_ret;
    logic [1:0]         r_idx, n_idx;
    logic               r_pass, n_pass;
    logic               r_neg, n_neg;
    logic [7:0]         r_n, n_n;
    logic [7:0]         r_cfg;
    logic signed [33:0] r_prod, n_prod;
    logic [31:0]        r_acc, n_acc;
    logic [29:0]        r_h2, n_h2;
    logic [31:0]        r_s, n_s;
    logic signed [15:0] r_raw [3];
    logic signed [15:0] n_raw [3];
    logic signed [15:0] r_out [3];
    logic signed [15:0] n_out [3];
    logic signed [15:0] r_vec [3];
    logic signed [15:0] n_vec [3];
    logic signed [15:0] r_tgt [3];
    logic signed [15:0] n_tgt [3];
    logic               r_ovalid, n_ovalid;
    t_dir               r_odata, n_odata;

    t_unit_req          w_req;
    t_unit_rsp          w_rsp;

    logic [7:0]         w_t;
    logic signed [15:0] w_s_cur, w_v_cur, w_cur;
    logic signed [16:0] w_diff;
    logic signed [16:0] w_ma, w_mb;
    logic signed [33:0] w_mp;
    logic signed [27:0] w_num;
    logic [27:0]        w_num_mag;
    logic signed [17:0] w_q, w_bl_sum;
    logic [15:0]        w_mag;
    logic [16:0]        w_qn;
    logic [15:0]        w_qc;
    logic [31:0]        w_h2x3;
    logic [16:0]        w_yr;
    logic               w_ofree;
    logic               w_accept;

    lds_unit u_unit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    // Blend register; zero acts as one
    assign w_t = (r_cfg == 8'd0) ? 8'd1 : r_cfg;

    // Operand selection for blend and normalize
    assign w_s_cur = r_pass ? r_out[r_idx] : r_raw[r_idx];
    assign w_v_cur = r_pass ? r_vec[r_idx] : r_tgt[r_idx];
    assign w_cur   = r_vec[r_idx];
    assign w_diff  = {w_v_cur[15], w_v_cur} - {w_s_cur[15], w_s_cur};

    // Shared multiplier: blend delta times ticks, or squares
    always_comb begin
        w_ma = {w_cur[15], w_cur};
        w_mb = {w_cur[15], w_cur};
        if (r_state == ST_BL_MUL) begin
            w_ma = w_diff;
            w_mb = {9'd0, r_n};
        end else if (r_state == ST_Y_MUL) begin
            w_ma = {r_vec[1][15], r_vec[1]};
            w_mb = {r_vec[1][15], r_vec[1]};
        end
    end
    assign w_mp = w_ma * w_mb;

    // Blend rounding: floor((2*d*n + T) / (2*T)) as sign and magnitude
    assign w_num = {r_prod[26:0], 1'b0} + 28'(w_t);
    assign w_num_mag = w_num[27] ? (28'(-w_num) + {19'd0, w_t, 1'b0} - 28'd1)
                                 : 28'(w_num);
    assign w_q      = {1'b0, w_rsp.res[16:0]};
    assign w_bl_sum = {{2{w_s_cur[15]}}, w_s_cur} + (r_neg ? -w_q : w_q);

    // Normalize: magnitude in, clamped quotient out
    assign w_mag = w_cur[15] ? 16'(-w_cur) : 16'(w_cur);
    assign w_qn  = w_rsp.res[16:0];
    assign w_qc  = (w_qn > 17'(ONE_Q14)) ? 16'(ONE_Q14) : w_qn[15:0];

    // Depression check and sine of sixty degrees times horizontal length
    assign w_h2x3 = {2'd0, r_h2} + {1'b0, r_h2, 1'b0};
    assign w_yr   = (w_rsp.res[16:0] + 17'd1) >> 1;

    assign w_ofree  = !r_ovalid || !i_out_stall;
    assign w_accept = (r_state == ST_IDLE) && i_in_valid;

    // Sequencer: next state, datapath updates and unit requests
    always_comb begin
        n_state  = r_state;
        n_ret    = r_ret;
        n_idx    = r_idx;
        n_pass   = r_pass;
        n_neg    = r_neg;
        n_n      = r_n;
        n_prod   = r_prod;
        n_acc    = r_acc;
        n_h2     = r_h2;
        n_s      = r_s;
        n_raw    = r_raw;
        n_out    = r_out;
        n_vec    = r_vec;
        n_tgt    = r_tgt;
        n_ovalid = r_ovalid && i_out_stall;
        n_odata  = r_odata;
        w_req    = '{start: 1'b0, op: OP_DIV, arg: 64'd0, den: 33'd0};

        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    if (i_in_data.target_y > 16'sd0) begin
                        n_tgt[0] = DEF_X;
                        n_tgt[1] = DEF_Y;
                        n_tgt[2] = 16'sd0;
                    end else begin
                        n_tgt[0] = i_in_data.target_x;
                        n_tgt[1] = i_in_data.target_y;
                        n_tgt[2] = i_in_data.target_z;
                    end
                    n_n     = (i_in_data.elapsed_ticks > w_t) ? w_t
                                                              : i_in_data.elapsed_ticks;
                    n_idx   = 2'd0;
                    n_pass  = 1'b0;
                    n_state = ST_BL_MUL;
                end
            end
            ST_BL_MUL: begin
                n_prod  = w_mp;
                n_state = ST_BL_DIV;
            end
            ST_BL_DIV: begin
                w_req.start = 1'b1;
                w_req.op    = OP_DIV;
                w_req.arg   = 64'(w_num_mag);
                w_req.den   = {24'd0, w_t, 1'b0};
                n_neg       = w_num[27];
                n_state     = ST_BL_WAIT;
            end
            ST_BL_WAIT: begin
                if (w_rsp.done) begin
                    if (r_pass) begin
                        n_out[r_idx] = w_bl_sum[15:0];
                    end else begin
                        n_raw[r_idx] = w_bl_sum[15:0];
                    end
                    if (r_idx == 2'd2) begin
                        n_idx   = 2'd0;
                        n_state = ST_BL_END;
                    end else begin
                        n_idx   = r_idx + 2'd1;
                        n_state = ST_BL_MUL;
                    end
                end
            end
            ST_BL_END: begin
                if (r_pass) begin
                    n_state = ST_GUARD;
                end else begin
                    n_vec   = r_raw;
                    n_ret   = RET_RAW;
                    n_acc   = 32'd0;
                    n_state = ST_NM_MUL;
                end
            end
            ST_GUARD: begin
                n_vec = r_out;
                if (r_out[0] < GUARD_Q14 && r_out[0] > -GUARD_Q14 &&
                    r_out[2] < GUARD_Q14 && r_out[2] > -GUARD_Q14) begin
                    n_vec[0] = GUARD_Q14;
                end
                n_ret   = RET_OUT;
                n_acc   = 32'd0;
                n_state = ST_NM_MUL;
            end
            ST_NM_MUL: begin
                n_prod  = w_mp;
                n_state = ST_NM_ACC;
            end
            ST_NM_ACC: begin
                n_acc = r_acc + r_prod[31:0];
                if (r_idx == 2'd2) begin
                    n_idx   = 2'd0;
                    n_state = ST_NM_SQRT;
                end else begin
                    n_idx   = r_idx + 2'd1;
                    n_state = ST_NM_MUL;
                end
            end
            ST_NM_SQRT: begin
                if (r_acc == 32'd0) begin
                    // Zero vector stays as it is
                    n_state = ST_NM_DIVWAIT;
                    n_idx   = 2'd2;
                end else begin
                    w_req.start = 1'b1;
                    w_req.op    = OP_SQRT;
                    w_req.arg   = {r_acc, 32'd0};
                    n_state     = ST_NM_SQWAIT;
                end
            end
            ST_NM_SQWAIT: begin
                if (w_rsp.done) begin
                    n_s     = w_rsp.res;
                    n_state = ST_NM_DIV;
                end
            end
            ST_NM_DIV: begin
                w_req.start = 1'b1;
                w_req.op    = OP_DIV;
                w_req.arg   = 64'({w_mag, 31'd0}) + 64'(r_s);
                w_req.den   = {r_s, 1'b0};
                n_neg       = w_cur[15];
                n_state     = ST_NM_DIVWAIT;
            end
            ST_NM_DIVWAIT: begin
                if (w_rsp.done || r_acc == 32'd0) begin
                    if (r_acc != 32'd0) begin
                        n_vec[r_idx] = r_neg ? 16'(-w_qc) : w_qc;
                    end
                    if (r_idx == 2'd2) begin
                        n_idx = 2'd0;
                        unique case (r_ret)
                            RET_RAW: begin
                                n_h2    = 30'd0;
                                n_state = ST_H2_MUL;
                            end
                            RET_SHAL: begin
                                n_pass  = 1'b1;
                                n_state = ST_BL_MUL;
                            end
                            RET_OUT: begin
                                n_state = ST_EMIT;
                            end
                            default: begin
                                n_state = ST_IDLE;
                            end
                        endcase
                    end else begin
                        n_idx   = r_idx + 2'd1;
                        n_state = ST_NM_DIV;
                    end
                end
            end
            ST_H2_MUL: begin
                n_prod  = w_mp;
                n_state = ST_H2_ACC;
            end
            ST_H2_ACC: begin
                n_h2 = r_h2 + r_prod[29:0];
                if (r_idx == 2'd0) begin
                    n_idx   = 2'd2;
                    n_state = ST_H2_MUL;
                end else begin
                    n_idx   = 2'd0;
                    n_state = ST_Y_MUL;
                end
            end
            ST_Y_MUL: begin
                if (r_h2 <= H2_MIN) begin
                    // Nearly vertical: point straight down
                    n_vec[0] = 16'sd0;
                    n_vec[1] = -ONE_Q14;
                    n_vec[2] = 16'sd0;
                    n_pass   = 1'b1;
                    n_state  = ST_BL_MUL;
                end else begin
                    n_prod  = w_mp;
                    n_state = ST_Y_CHK;
                end
            end
            ST_Y_CHK: begin
                n_ret = RET_SHAL;
                n_acc = 32'd0;
                if (!r_vec[1][15] || r_prod[31:0] < w_h2x3) begin
                    w_req.start = 1'b1;
                    w_req.op    = OP_SQRT;
                    w_req.arg   = 64'(w_h2x3);
                    n_state     = ST_Y_SQWAIT;
                end else begin
                    n_state = ST_NM_MUL;
                end
            end
            ST_Y_SQWAIT: begin
                if (w_rsp.done) begin
                    n_vec[1] = 16'(17'd0 - w_yr);
                    n_state  = ST_NM_MUL;
                end
            end
            ST_EMIT: begin
                if (w_ofree) begin
                    n_out          = r_vec;
                    n_ovalid       = 1'b1;
                    n_odata.dir_x  = r_vec[0];
                    n_odata.dir_y  = r_vec[1];
                    n_odata.dir_z  = r_vec[2];
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_ret    <= RET_RAW;
            r_idx    <= 2'd0;
            r_pass   <= 1'b0;
            r_ovalid <= 1'b0;
            r_cfg    <= CFG_RESET;
            r_raw    <= '{3{16'sd0}};
            r_out    <= '{3{16'sd0}};
        end else begin
            r_state  <= n_state;
            r_ret    <= n_ret;
            r_idx    <= n_idx;
            r_pass   <= n_pass;
            r_ovalid <= n_ovalid;
            r_raw    <= n_raw;
            r_out    <= n_out;
            if (i_cfg_we) begin
                r_cfg <= i_cfg_data;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_neg   <= n_neg;
        r_n     <= n_n;
        r_prod  <= n_prod;
        r_acc   <= n_acc;
        r_h2    <= n_h2;
        r_s     <= n_s;
        r_vec   <= n_vec;
        r_tgt   <= n_tgt;
        r_odata <= n_odata;
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_odata;

endmodule

`default_nettype wire

@@ verif/light_direction_smoother_test.sv @@
// Testbench for light_direction_smoother: drives target directions and checks each
// smoothed direction against an in-bench fixed-point predictor.
// Depends on lds_pkg and the light_direction_smoother RTL.
`timescale 1ns / 100ps

module light_direction_smoother_test;
    import lds_pkg::*;

    localparam int IDLE_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 600;
    localparam int HOLD_CYCLES = 3000;

    logic    clk = 1'b0;
    logic    rst_n = 1'b0;
    logic    in_valid = 1'b0;
    logic    in_stall;
    t_target in_data = '0;
    logic    out_valid;
    logic    out_stall = 1'b0;
    t_dir    out_data;
    logic    cfg_we = 1'b0;
    logic [7:0] cfg_data = '0;

    // predictor state
    logic [7:0]  blend_ticks;
    longint      raw_vec[3];
    longint      smooth_vec[3];
    t_dir        expected_dirs[$];
    int          mismatches = 0;
    int          idle_cycles = 0;
    bit          hold_req = 1'b0;
    bit          hold_taken = 1'b0;
    int          hold_len = 0;
    int          rx_wait = 0;

    light_direction_smoother i_dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .o_in_stall(in_stall), .i_in_data(in_data),
        .o_out_valid(out_valid), .i_out_stall(out_stall), .o_out_data(out_data),
        .i_cfg_we(cfg_we), .i_cfg_data(cfg_data)
    );

    always #10 clk = ~clk;

    function automatic longint unsigned int_sqrt(longint unsigned x);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b >>= 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint div_floor(longint num, longint den);
        if (num >= 0) return num / den;
        return -((-num + den - 1) / den);
    endfunction

    // move s toward v by min(t,T)/T, rounded half up
    task automatic blend_toward(ref longint s[3], input longint v[3], input int t);
        longint tt, n;
        tt = (blend_ticks == 0) ? 1 : blend_ticks;
        n = (t > tt) ? tt : t;
        for (int i = 0; i < 3; i++)
            s[i] = s[i] + div_floor(2 * (v[i] - s[i]) * n + tt, 2 * tt);
    endtask

    task automatic to_unit(ref longint v[3]);
        longint unsigned l2, root, mag, q;
        l2 = 0;
        for (int i = 0; i < 3; i++) l2 += v[i] * v[i];
        if (l2 == 0) return;
        root = int_sqrt(l2 << 32);
        for (int i = 0; i < 3; i++) begin
            mag = (v[i] < 0) ? -v[i] : v[i];
            q = ((mag << 31) + root) / (2 * root);
            if (q > 16384) q = 16384;
            v[i] = (v[i] < 0) ? -longint'(q) : longint'(q);
        end
    endtask

    task automatic predict_direction(input t_target tr);
        longint tgt[3], a[3], h2;
        longint unsigned r;
        t_dir d;
        tgt[0] = tr.target_x;
        tgt[1] = tr.target_y;
        tgt[2] = tr.target_z;
        // replace upward targets with the downward default
        if (tgt[1] > 0) begin
            tgt[0] = DEF_X;
            tgt[1] = DEF_Y;
            tgt[2] = 0;
        end
        blend_toward(raw_vec, tgt, tr.elapsed_ticks);
        a = raw_vec;
        to_unit(a);
        h2 = a[0] * a[0] + a[2] * a[2];
        if (h2 <= 2) begin
            a[0] = 0;
            a[1] = -16384;
            a[2] = 0;
        end else begin
            // if y is not below a 60 degree depression, set it to minus sin(60) times the horizontal length
            if (a[1] >= 0 || a[1] * a[1] < 3 * h2) begin
                r = int_sqrt(3 * h2);
                a[1] = -longint'((r + 1) >> 1);
            end
            to_unit(a);
        end
        blend_toward(smooth_vec, a, tr.elapsed_ticks);
        if (smooth_vec[0] < 164 && smooth_vec[0] > -164 &&
            smooth_vec[2] < 164 && smooth_vec[2] > -164)
            smooth_vec[0] = 164;
        to_unit(smooth_vec);
        d.dir_x = 16'(smooth_vec[0]);
        d.dir_y = 16'(smooth_vec[1]);
        d.dir_z = 16'(smooth_vec[2]);
        expected_dirs.push_back(d);
    endtask

    // send one transaction after a random gap; valid drops only across a gap
    task automatic send_target(input t_target tr);
        int gap;
        gap = $urandom_range(0, 11);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= tr;
        predict_direction(tr);
        do @(posedge clk); while (in_stall);
    endtask

    // drop valid right after the last accepted transaction of a sequence
    task automatic stop_sending();
        in_valid <= 1'b0;
    endtask

    task automatic send_fields(input int x, input int y, input int z, input int t);
        t_target tr;
        tr.target_x = 16'(x);
        tr.target_y = 16'(y);
        tr.target_z = 16'(z);
        tr.elapsed_ticks = 8'(t);
        send_target(tr);
    endtask

    task automatic write_blend_ticks(input logic [7:0] val);
        stop_sending();
        while (expected_dirs.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        blend_ticks = val;
    endtask

    task automatic test_directed();
        send_fields(0, 0, 0, 0);
        send_fields(0, 0, 0, 255);
        send_fields(-32768, -32768, -32768, 25);
        send_fields(32767, -1, 32767, 26);
        send_fields(-32768, 32767, 32767, 10);
        send_fields(0, 1, 0, 255);
        send_fields(0, -16384, 0, 255);
        send_fields(1, -16384, 1, 255);
        send_fields(16384, 0, 0, 255);
        send_fields(16384, -1000, -16384, 3);
        send_fields(0, -16384, 0, 1);
        send_fields(-100, -16384, 100, 200);
        send_fields(32767, -32768, -32768, 128);
        send_fields(-1, -1, -1, 255);
        send_fields(20000, 0, -5, 25);
    endtask

    task automatic test_random(input int count);
        t_target tr;
        for (int k = 0; k < count; k++) begin
            tr.target_x = 16'($urandom);
            tr.target_y = 16'($urandom);
            tr.target_z = 16'($urandom);
            tr.elapsed_ticks = 8'($urandom);
            case ($urandom_range(0, 5))
                0: tr.elapsed_ticks = 8'($urandom_range(0, 3));
                1: tr.target_y = 16'(-int'($urandom_range(0, 16384)));
                2: begin
                    tr.target_x = 16'(int'($urandom_range(0, 300)) - 150);
                    tr.target_z = 16'(int'($urandom_range(0, 300)) - 150);
                end
                default: ;
            endcase
            send_target(tr);
        end
    endtask

    // stall the output long enough for the block to back up its input
    task automatic test_back_pressure();
        hold_req = 1'b1;
        test_random(6);
    endtask

    // receiver: draw a wait per result, long hold-off once on request
    always @(posedge clk) begin : receiver
        int draw;
        if (hold_req && !hold_taken) begin
            hold_taken <= 1'b1;
            hold_len <= HOLD_CYCLES;
            out_stall <= 1'b1;
        end else if (hold_len > 0) begin
            hold_len <= hold_len - 1;
            out_stall <= 1'b1;
        end else if (rx_wait > 0) begin
            rx_wait <= rx_wait - 1;
            out_stall <= 1'b1;
        end else if (out_valid && !out_stall) begin
            draw = $urandom_range(0, 11);
            rx_wait <= (draw == 0) ? 0 : draw - 1;
            out_stall <= (draw != 0);
        end else begin
            out_stall <= 1'b0;
        end
    end

    // compare each accepted result with the oldest expectation
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            if (expected_dirs.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %0d %0d %0d",
                             out_data.dir_x, out_data.dir_y, out_data.dir_z);
            end else begin
                t_dir e;
                e = expected_dirs.pop_front();
                if (e !== out_data) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch exp %0d %0d %0d got %0d %0d %0d",
                                 e.dir_x, e.dir_y, e.dir_z,
                                 out_data.dir_x, out_data.dir_y, out_data.dir_z);
                end
            end
        end
    end

    // watchdog on cycles without any accepted transaction
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n ||
            hold_len > 0)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("light_direction_smoother_test NOT OK");
            $finish;
        end
    end

    initial begin
        blend_ticks = CFG_RESET;
        for (int i = 0; i < 3; i++) begin
            raw_vec[i] = 0;
            smooth_vec[i] = 0;
        end
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_back_pressure();
        write_blend_ticks(8'd1);
        test_random(300);
        write_blend_ticks(8'd255);
        send_fields(16384, 0, 0, 255);
        send_fields(-16384, -100, 0, 254);
        test_random(300);
        write_blend_ticks(8'd0);
        test_random(200);
        write_blend_ticks(8'd7);
        test_random(400);
        write_blend_ticks(8'd25);
        test_random(430);
        stop_sending();
        while (expected_dirs.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("light_direction_smoother_test OK");
        else
            $display("light_direction_smoother_test NOT OK");
        $finish;
    end
endmodule
